FILE: rtl/assert_macros.svh
// Assertion macros for the checker file of the hasher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sha256_pkg.sv
// Types, constants and round functions shared by the SHA-256 hasher modules.
`default_nettype none

package sha256_pkg;

    localparam int WORD_W = 32;
    localparam int BLOCK_W = 512;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [7:0] ZERO_BYTE = 8'h00;
    localparam logic [6:0] LEN_FILL = 7'd56;
    localparam logic [6:0] BLOCK_BYTES = 7'd64;
    localparam logic [6:0] LAST_BYTE = 7'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_WORD_IDX = 3'd7;
    localparam logic [63:0] BITS_PER_BYTE = 64'd8;

    localparam logic [31:0] IV [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TABLE [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PAD  = 5'b00010,
        ST_COMP = 5'b00100,
        ST_ADD  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    typedef struct packed {
        logic       shift_byte;
        logic [7:0] byte_data;
        logic       shift_len;
        logic       step;
        logic       count_byte;
        logic       clear_len;
    } sched_ctl_t;

    typedef struct packed {
        logic       load;
        logic       round;
        logic [5:0] round_idx;
        logic       accum;
        logic       reinit;
    } core_ctl_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sha256_sched.sv
// Block buffer, rolling message schedule and message bit counter.
`default_nettype none

module sha256_sched
    import sha256_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire sched_ctl_t  ctl,
    output logic [31:0]      round_word
);

    // Word i of the block sits at bits [511-32*i -: 32]; bytes enter at the low end.
    logic [BLOCK_W-1:0] buf_reg;
    logic [BLOCK_W-1:0] buf_next;
    logic [63:0]        bits_reg;
    logic [63:0]        bits_next;
    logic [31:0]        w0;
    logic [31:0]        w1;
    logic [31:0]        w9;
    logic [31:0]        w14;
    logic [31:0]        sched_word;

    assign w0  = buf_reg[BLOCK_W - 1 -: WORD_W];
    assign w1  = buf_reg[BLOCK_W - 1 - WORD_W -: WORD_W];
    assign w9  = buf_reg[BLOCK_W - 1 - 9 * WORD_W -: WORD_W];
    assign w14 = buf_reg[BLOCK_W - 1 - 14 * WORD_W -: WORD_W];

    assign sched_word = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;
    assign round_word = w0;

    always_comb
    begin
        buf_next = buf_reg;
        if (ctl.shift_byte)
        begin
            buf_next = {buf_reg[BLOCK_W - 9:0], ctl.byte_data};
        end
        else if (ctl.shift_len)
        begin
            buf_next = {buf_reg[BLOCK_W - 65:0], bits_reg};
        end
        else if (ctl.step)
        begin
            buf_next = {buf_reg[BLOCK_W - WORD_W - 1:0], sched_word};
        end
    end

    always_comb
    begin
        bits_next = bits_reg;
        if (ctl.clear_len)
        begin
            bits_next = '0;
        end
        else if (ctl.count_byte)
        begin
            bits_next = bits_reg + BITS_PER_BYTE;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= '0;
        end
        else
        begin
            bits_reg <= bits_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sha256_core.sv
// Shared compression round unit with working variables and chaining words.
`default_nettype none

module sha256_core
    import sha256_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire core_ctl_t   ctl,
    input  wire logic [31:0] round_word,
    input  wire logic [2:0]  word_sel,
    output logic [31:0]      digest_word
);

    logic [31:0] chain_reg [0:7];
    logic [31:0] var_reg [0:7];
    logic [31:0] var_next [0:7];
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch_val;
    logic [31:0] maj_val;

    assign ch_val  = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
    assign maj_val = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
                   ^ (var_reg[1] & var_reg[2]);
    assign t1 = var_reg[7] + big_sigma1(var_reg[4]) + ch_val + K_TABLE[ctl.round_idx]
              + round_word;
    assign t2 = big_sigma0(var_reg[0]) + maj_val;

    always_comb
    begin
        var_next = var_reg;
        if (ctl.load)
        begin
            var_next = chain_reg;
        end
        else if (ctl.round)
        begin
            var_next[0] = t1 + t2;
            var_next[1] = var_reg[0];
            var_next[2] = var_reg[1];
            var_next[3] = var_reg[2];
            var_next[4] = var_reg[3] + t1;
            var_next[5] = var_reg[4];
            var_next[6] = var_reg[5];
            var_next[7] = var_reg[6];
        end
    end

    always_ff @(posedge clk)
    begin
        var_reg <= var_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= IV[i];
            end
        end
        else if (ctl.reinit)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= IV[i];
            end
        end
        else if (ctl.accum)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= chain_reg[i] + var_reg[i];
            end
        end
    end

    assign digest_word = chain_reg[word_sel];

endmodule

`default_nettype wire

FILE: rtl/sha256_ctrl.sv
// Sequencer for byte loading, padding, compression rounds and digest output.
`default_nettype none

module sha256_ctrl
    import sha256_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [7:0] data_byte,
    input  wire logic       byte_valid,
    input  wire logic       end_of_message,
    output logic            in_stall,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [2:0]      word_index,
    output logic            last_word,
    output sched_ctl_t      sched_ctl,
    output core_ctl_t       core_ctl
);

    state_t     state_reg;
    state_t     state_next;
    logic [6:0] fill_reg;
    logic [6:0] fill_next;
    logic [5:0] round_reg;
    logic [5:0] round_next;
    logic [2:0] widx_reg;
    logic [2:0] widx_next;
    logic       end_pend_reg;
    logic       end_pend_next;
    logic       final_reg;
    logic       final_next;
    logic       pad80_reg;
    logic       pad80_next;

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        round_next    = round_reg;
        widx_next     = widx_reg;
        end_pend_next = end_pend_reg;
        final_next    = final_reg;
        pad80_next    = pad80_reg;
        in_stall      = 1'b1;
        out_valid     = 1'b0;
        sched_ctl     = '0;
        core_ctl      = '0;
        core_ctl.round_idx = round_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (byte_valid)
                    begin
                        sched_ctl.shift_byte = 1'b1;
                        sched_ctl.byte_data  = data_byte;
                        sched_ctl.count_byte = 1'b1;
                        fill_next = fill_reg + 7'd1;
                    end
                    if (byte_valid && fill_reg == LAST_BYTE)
                    begin
                        // A full block is compressed before any end handling.
                        fill_next     = '0;
                        round_next    = '0;
                        core_ctl.load = 1'b1;
                        end_pend_next = end_of_message;
                        pad80_next    = end_of_message;
                        final_next    = 1'b0;
                        state_next    = ST_COMP;
                    end
                    else if (end_of_message)
                    begin
                        end_pend_next = 1'b1;
                        pad80_next    = 1'b1;
                        state_next    = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                if (pad80_reg)
                begin
                    sched_ctl.shift_byte = 1'b1;
                    sched_ctl.byte_data  = PAD_BYTE;
                    fill_next  = fill_reg + 7'd1;
                    pad80_next = 1'b0;
                end
                else if (fill_reg == BLOCK_BYTES)
                begin
                    // The pad byte spilled past the length field: an extra block.
                    fill_next     = '0;
                    round_next    = '0;
                    core_ctl.load = 1'b1;
                    final_next    = 1'b0;
                    state_next    = ST_COMP;
                end
                else if (fill_reg == LEN_FILL)
                begin
                    sched_ctl.shift_len = 1'b1;
                    fill_next     = '0;
                    round_next    = '0;
                    core_ctl.load = 1'b1;
                    final_next    = 1'b1;
                    state_next    = ST_COMP;
                end
                else
                begin
                    sched_ctl.shift_byte = 1'b1;
                    sched_ctl.byte_data  = ZERO_BYTE;
                    fill_next = fill_reg + 7'd1;
                end
            end
            ST_COMP:
            begin
                core_ctl.round = 1'b1;
                sched_ctl.step = 1'b1;
                round_next     = round_reg + 6'd1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                core_ctl.accum = 1'b1;
                if (final_reg)
                begin
                    widx_next  = '0;
                    state_next = ST_OUT;
                end
                else if (end_pend_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    widx_next = widx_reg + 3'd1;
                    if (widx_reg == LAST_WORD_IDX)
                    begin
                        core_ctl.reinit     = 1'b1;
                        sched_ctl.clear_len = 1'b1;
                        fill_next     = '0;
                        end_pend_next = 1'b0;
                        final_next    = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            round_reg    <= '0;
            widx_reg     <= '0;
            end_pend_reg <= 1'b0;
            final_reg    <= 1'b0;
            pad80_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            round_reg    <= round_next;
            widx_reg     <= widx_next;
            end_pend_reg <= end_pend_next;
            final_reg    <= final_next;
            pad80_reg    <= pad80_next;
        end
    end

    assign word_index = widx_reg;
    assign last_word  = (widx_reg == LAST_WORD_IDX);

endmodule

`default_nettype wire

FILE: rtl/sha256_byte_stream_hasher_top.sv
// Top level of the SHA-256 byte stream hasher.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+---------------------------------------
//  input   | in_valid / in_stall  | data_byte, byte_valid, end_of_message
//  output  | out_valid / out_stall| digest_word, word_index, last_word
//
// A byte that does not fill the block is taken without a stall; one that fills it stalls
// the input while the single round unit runs its 64 rounds and the result is folded into
// the chaining words. The end item adds padding bytes and one or two compressions, then
// eight digest words, one per accepted output request; out_stall holds the current word.
// Reset is asynchronous and leaves the hasher idle with the initial hash values.
`default_nettype none

module sha256_byte_stream_hasher_top
    import sha256_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_valid,
    input  wire logic        end_of_message,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);

    sched_ctl_t  sched_ctl;
    core_ctl_t   core_ctl;
    logic [31:0] round_word;

    sha256_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .data_byte      (data_byte),
        .byte_valid     (byte_valid),
        .end_of_message (end_of_message),
        .in_stall       (in_stall),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .word_index     (word_index),
        .last_word      (last_word),
        .sched_ctl      (sched_ctl),
        .core_ctl       (core_ctl)
    );

    sha256_sched u_sched (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (sched_ctl),
        .round_word (round_word)
    );

    sha256_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (core_ctl),
        .round_word  (round_word),
        .word_sel    (word_index),
        .digest_word (digest_word)
    );

endmodule

`default_nettype wire

FILE: rtl/sha256_checker.sv
// Port-level checker for the hasher, attached to the top level by bind.
`default_nettype none

`include "assert_macros.svh"

module sha256_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        end_of_message,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] digest_word,
    input wire logic [2:0]  word_index,
    input wire logic        last_word
);

    // Input is held off for the whole time the digest is being delivered.
    `ASSERT_IMPLY(a_no_input_during_output, clk, rst_n, out_valid, in_stall,
        "input taken during digest output")

    `ASSERT_IMPLY(a_last_word_flag, clk, rst_n, out_valid, last_word == (word_index == 3'd7),
        "last_word does not match word_index")

    // Digest words follow one another in order without gaps in the sequencer.
    `ASSERT_NEXT(a_word_order, clk, rst_n, out_valid && !out_stall && !last_word,
        out_valid && word_index == $past(word_index) + 3'd1, "digest word order broken")

    // An end request leads into padding or into a compression, so the input closes next cycle.
    `ASSERT_NEXT(a_end_closes_input, clk, rst_n, in_valid && !in_stall && end_of_message,
        in_stall, "input open after end request")

    `ASSERT_NEXT(a_stalled_word_holds, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(digest_word) && $stable(word_index), "stalled digest word changed")

endmodule

bind sha256_byte_stream_hasher_top sha256_checker u_sha256_checker (.*);

`default_nettype wire
